[hdl/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight unit.
package glos_pkg;

  // Fixed field widths.
  localparam int COORD_W    = 10;
  localparam int CELL_IDX_W = 8;
  localparam int CELL_W     = 2;
  localparam int GRID_DIM_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Default store dimensions.
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  // Reset value of the grid size registers.
  localparam logic [GRID_DIM_W-1:0] GRID_DIM_RESET = 9'd256;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_write;
    logic accept_cast;
    logic walk;
    logic finish;
  } glos_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic walk_end;
  } glos_status_t;

endpackage

[hdl/glos_ram.sv]
// Generic simple dual-port RAM with registered read.
module glos_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/glos_ctrl.sv]
// Controller state machine for the grid line-of-sight unit.
module glos_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  cmd,
  input  glos_pkg::glos_status_t status,
  output logic                  busy,
  output glos_pkg::glos_cmd_t   ctrl
);

  glos_pkg::state_t state;
  glos_pkg::state_t state_next;
  logic             walk_over;

  assign walk_over = status.hit | status.walk_end;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glos_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      glos_pkg::ST_IDLE: begin
        if (start && cmd == glos_pkg::CMD_CAST) begin
          state_next = glos_pkg::ST_WALK;
        end
      end
      glos_pkg::ST_WALK: begin
        if (walk_over) begin
          state_next = glos_pkg::ST_IDLE;
        end
      end
      default: state_next = glos_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl = '0;
    busy = 1'b0;
    unique case (state)
      glos_pkg::ST_IDLE: begin
        ctrl.accept_write = start && cmd == glos_pkg::CMD_WRITE;
        ctrl.accept_cast  = start && cmd == glos_pkg::CMD_CAST;
      end
      glos_pkg::ST_WALK: begin
        busy        = 1'b1;
        ctrl.walk   = !walk_over;
        ctrl.finish = walk_over;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

[hdl/glos_dp.sv]
// Datapath: grid size registers, obstacle map and the ray walker.
module glos_dp #(
  parameter int MAX_COLS = glos_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = glos_pkg::DEF_MAX_ROWS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  glos_pkg::glos_cmd_t                   ctrl,
  output glos_pkg::glos_status_t                status,
  input  logic                                  cfg_wr,
  input  logic [glos_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [glos_pkg::GRID_DIM_W-1:0]       cfg_data,
  input  logic [glos_pkg::CELL_IDX_W-1:0]       cell_col,
  input  logic [glos_pkg::CELL_IDX_W-1:0]       cell_row,
  input  logic [glos_pkg::CELL_W-1:0]           cell_bits,
  input  logic signed [glos_pkg::COORD_W-1:0]   ray_start_col,
  input  logic signed [glos_pkg::COORD_W-1:0]   ray_start_row,
  input  logic signed [glos_pkg::COORD_W-1:0]   ray_end_col,
  input  logic signed [glos_pkg::COORD_W-1:0]   ray_end_row,
  output logic                                  done,
  output logic                                  blocked
);

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  // Grid size registers and their values clamped to the store.
  logic [glos_pkg::GRID_DIM_W-1:0] grid_width;
  logic [glos_pkg::GRID_DIM_W-1:0] grid_height;
  logic [glos_pkg::GRID_DIM_W-1:0] eff_width;
  logic [glos_pkg::GRID_DIM_W-1:0] eff_height;

  // Walker state.
  logic signed [9:0]  x;
  logic signed [9:0]  y;
  logic signed [12:0] err;
  logic [10:0]        dx2;
  logic [10:0]        dy2;
  logic [11:0]        left;
  logic               xs;
  logic               ys;
  logic               ns;
  logic               ew;

  // Read stage.
  logic               rd_vld;
  logic               rd_oob;
  logic [1:0]         rd_bits;

  // Combinational helpers.
  logic signed [10:0] diff_x;
  logic signed [10:0] diff_y;
  logic [9:0]         abs_x;
  logic [9:0]         abs_y;
  logic               issue;
  logic               oob;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic signed [12:0] dx2_s;
  logic signed [12:0] dy2_s;
  logic signed [12:0] err_next;
  logic signed [9:0]  x_next;
  logic signed [9:0]  y_next;
  logic [11:0]        left_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= glos_pkg::GRID_DIM_RESET;
      grid_height <= glos_pkg::GRID_DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        glos_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        glos_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_width  = (32'(grid_width) > MAX_COLS)  ? 9'(MAX_COLS) : grid_width;
  assign eff_height = (32'(grid_height) > MAX_ROWS) ? 9'(MAX_ROWS) : grid_height;

  // Map writes; cells outside the store are dropped.
  assign wr_en   = ctrl.accept_write && (32'(cell_col) < MAX_COLS)
                   && (32'(cell_row) < MAX_ROWS);
  assign wr_addr = AW'(cell_row) * AW'(MAX_COLS) + AW'(cell_col);

  // Ray set-up values.
  assign diff_x = 11'(ray_end_col) - 11'(ray_start_col);
  assign diff_y = 11'(ray_end_row) - 11'(ray_start_row);
  assign abs_x  = diff_x[10] ? 10'(-diff_x) : diff_x[9:0];
  assign abs_y  = diff_y[10] ? 10'(-diff_y) : diff_y[9:0];

  // Current cell: bounds test and map address.
  assign oob     = x[9] || y[9] || (x[8:0] >= eff_width) || (y[8:0] >= eff_height);
  assign rd_addr = oob ? '0 : AW'(y[8:0]) * AW'(MAX_COLS) + AW'(x[8:0]);
  assign issue   = ctrl.walk && (left != '0);

  // One error-term step of the walk.
  assign dx2_s = 13'(dx2);
  assign dy2_s = 13'(dy2);
  always_comb begin
    x_next    = x;
    y_next    = y;
    err_next  = err;
    left_next = left - 12'd1;
    if (!err[12] && err != '0) begin
      x_next   = xs ? x + 10'sd1 : x - 10'sd1;
      err_next = err - dy2_s;
    end else if (err[12]) begin
      y_next   = ys ? y + 10'sd1 : y - 10'sd1;
      err_next = err + dx2_s;
    end else begin
      x_next    = xs ? x + 10'sd1 : x - 10'sd1;
      y_next    = ys ? y + 10'sd1 : y - 10'sd1;
      err_next  = err + dx2_s - dy2_s;
      left_next = (left > 12'd2) ? left - 12'd2 : '0;
    end
  end

  // Walker registers.
  always_ff @(posedge clk) begin
    if (ctrl.accept_cast) begin
      x    <= ray_start_col;
      y    <= ray_start_row;
      xs   <= ray_end_col > ray_start_col;
      ys   <= ray_end_row > ray_start_row;
      dx2  <= {1'b0, abs_x} << 1;
      dy2  <= {1'b0, abs_y} << 1;
      err  <= 13'(abs_x) - 13'(abs_y);
      left <= 12'd1 + 12'(abs_x) + 12'(abs_y);
      ns   <= abs_y >= abs_x;
      ew   <= abs_x >= abs_y;
    end else if (issue) begin
      x    <= x_next;
      y    <= y_next;
      err  <= err_next;
      left <= left_next;
    end
  end

  // Read stage tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_oob <= oob;
    end
  end

  glos_ram #(
    .WIDTH (glos_pkg::CELL_W),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cell_bits),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // Cell test on the returned map bits.
  assign status.hit      = rd_vld && (rd_oob || (ns && rd_bits[0]) || (ew && rd_bits[1]));
  assign status.walk_end = (left == '0) && !rd_vld;

  // Result strobe and value.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      blocked <= status.hit;
    end
  end

endmodule

[hdl/grid_line_of_sight_unit.sv]
// Top level of the grid line-of-sight unit.
//
// An item is taken at a clock edge with start high and busy low. cmd selects
// a map write (cell_col, cell_row, cell_bits) or a ray cast (ray_* points).
// A write gives no result and leaves busy low, so writes may follow each
// other every cycle. A cast raises busy and walks the grid line, one map
// read per visited cell through the single read port of the obstacle map.
// A cast whose walk runs through k cells to its end point, or is stopped
// by an obstacle at its k-th cell, strobes done for one cycle, with
// blocked valid. k is at most |dx| + |dy| + 1, and inside the 256 by 256
// map no walk reads more than 511 cells. busy falls as done rises, so the
// next item can be taken then. The receiver cannot stall: done is shown
// for exactly one cycle, and blocked holds until the next result.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always ready
// and are to be made while no cast is in flight; indexes past the grid
// height register are ignored. Reset clears the controller and sets the
// grid size to 256 by 256; the map holds no defined value until written,
// and no cast may read a cell that was never written.
module grid_line_of_sight_unit #(
  parameter int MAX_COLS = glos_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = glos_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [glos_pkg::CELL_IDX_W-1:0]     cell_col,
  input  logic [glos_pkg::CELL_IDX_W-1:0]     cell_row,
  input  logic [glos_pkg::CELL_W-1:0]         cell_bits,
  input  logic signed [glos_pkg::COORD_W-1:0] ray_start_col,
  input  logic signed [glos_pkg::COORD_W-1:0] ray_start_row,
  input  logic signed [glos_pkg::COORD_W-1:0] ray_end_col,
  input  logic signed [glos_pkg::COORD_W-1:0] ray_end_row,
  output logic                                done,
  output logic                                blocked,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glos_pkg::GRID_DIM_W-1:0]     cfg_data
);

  glos_pkg::glos_cmd_t    ctrl;
  glos_pkg::glos_status_t status;

  assign cfg_ready = 1'b1;

  glos_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  glos_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .cell_bits     (cell_bits),
    .ray_start_col (ray_start_col),
    .ray_start_row (ray_start_row),
    .ray_end_col   (ray_end_col),
    .ray_end_row   (ray_end_row),
    .done          (done),
    .blocked       (blocked)
  );

  // A result is only reported once the walk has ended.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobed while a cast is still in flight");

  // The result strobe lasts one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A cast item occupies the unit from the next cycle on.
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == glos_pkg::CMD_CAST) |=> busy)
    else $error("cast item accepted but unit not busy");

  // A write item gives no result and keeps the unit free.
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == glos_pkg::CMD_WRITE) |=> (!busy && !done))
    else $error("write item produced a result or raised busy");

endmodule

[tb/tb.sv]
// Testbench for the grid line-of-sight unit: map writes, ray casts and grid size settings.
`timescale 1ns / 100ps

module tb;
  import glos_pkg::*;

  localparam int MAP_CELLS   = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam int EXP_CALC    = -1;     // expected value comes from the predictor
  localparam int SETTLE_CYC  = 4;
  localparam int DRAIN_LIMIT = 4000;
  localparam int DIR_N       = 30;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 84;
  localparam int WIN_CELLS   = 16;     // side of the corner window cleared first
  localparam int CAST_TRIES  = 8;

  // Register indexes that the block ignores.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  // Grid size and idling of each random phase.
  localparam int PHASE_W [N_PHASES] = '{256, 16, 511, 1, 0, 100, 256, 33};
  localparam int PHASE_H [N_PHASES] = '{256, 12, 300, 256, 7, 37, 1, 511};
  localparam bit PHASE_IDLE [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_CAST,
    ROW_CFG
  } row_kind_t;

  // One directed row: a write (col, row, bits), a cast (four end point
  // coordinates) or a register write (index, value).
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    int        c;
    int        d;
    int        expv;
  } dir_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              cmd = CMD_WRITE;
  logic [CELL_IDX_W-1:0]             cell_col = '0;
  logic [CELL_IDX_W-1:0]             cell_row = '0;
  logic [CELL_W-1:0]                 cell_bits = '0;
  logic signed [COORD_W-1:0]         ray_start_col = '0;
  logic signed [COORD_W-1:0]         ray_start_row = '0;
  logic signed [COORD_W-1:0]         ray_end_col = '0;
  logic signed [COORD_W-1:0]         ray_end_row = '0;
  logic                              done;
  logic                              blocked;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index = '0;
  logic [GRID_DIM_W-1:0]             cfg_data = '0;

  // Predictor state: copy of the obstacle map and of the grid size.
  // Cells never written stay unknown.
  logic [CELL_W-1:0]     map_cells [0:MAP_CELLS-1];
  logic [GRID_DIM_W-1:0] grid_w = GRID_DIM_RESET;
  logic [GRID_DIM_W-1:0] grid_h = GRID_DIM_RESET;

  logic     blocked_exp_q [$];
  dir_row_t dir_tab [DIR_N];
  bit       idle_en = 1'b0;
  int       n_err = 0;
  int       n_casts = 0;
  int       n_writes = 0;
  int       n_hits = 0;
  int       n_cfg = 0;

  grid_line_of_sight_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .cell_bits     (cell_bits),
    .ray_start_col (ray_start_col),
    .ray_start_row (ray_start_row),
    .ray_end_col   (ray_end_col),
    .ray_end_row   (ray_end_row),
    .done          (done),
    .blocked       (blocked),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the grid line with the error-term traversal and report whether any
  // visited cell stops the ray. Cells outside the grid in use always stop it.
  // A walk that reads a cell never written gives an unknown result.
  function automatic logic ray_blocked(int sc, int sr, int ec, int er);
    int       dx, dy, x, y, left, xs, ys, err, w, h;
    logic     ns, ew;
    logic [CELL_W-1:0] v;
    w    = (int'(grid_w) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(grid_w);
    h    = (int'(grid_h) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(grid_h);
    dx   = (ec > sc) ? ec - sc : sc - ec;
    dy   = (er > sr) ? er - sr : sr - er;
    x    = sc;
    y    = sr;
    left = 1 + dx + dy;
    xs   = (ec > sc) ? 1 : -1;
    ys   = (er > sr) ? 1 : -1;
    err  = dx - dy;
    dx   = 2 * dx;
    dy   = 2 * dy;
    ns   = (dy >= dx);
    ew   = (dx >= dy);
    while (left > 0) begin
      if (x < 0 || x >= w || y < 0 || y >= h) return 1'b1;
      v = map_cells[y * DEF_MAX_COLS + x];
      if ($isunknown(v)) return 1'bx;
      if ((ns && v[0]) || (ew && v[1])) return 1'b1;
      if (err > 0) begin
        x   = x + xs;
        err = err - dy;
      end else if (err < 0) begin
        y   = y + ys;
        err = err + dx;
      end else begin
        // Exact diagonal tie: step both axes and skip the corner cell.
        x    = x + xs;
        y    = y + ys;
        err  = err + dx - dy;
        left = left - 1;
      end
      left = left - 1;
    end
    return 1'b0;
  endfunction

  // Present one item and hold it until the block takes it. All fields are
  // driven from a..d: a write uses col, row and bits, a cast the end points.
  task automatic send_item(input logic op, input int a, input int b, input int c,
                           input int d, input int fixed_exp);
    logic expv;
    if (idle_en) begin
      while ($urandom_range(99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    cmd           <= op;
    cell_col      <= CELL_IDX_W'(a);
    cell_row      <= CELL_IDX_W'(b);
    cell_bits     <= CELL_W'(c);
    ray_start_col <= COORD_W'(a);
    ray_start_row <= COORD_W'(b);
    ray_end_col   <= COORD_W'(c);
    ray_end_row   <= COORD_W'(d);
    do @(posedge clk); while (busy);
    if (op == CMD_CAST) begin
      expv = (fixed_exp == EXP_CALC) ? ray_blocked(a, b, c, d) : fixed_exp[0];
      blocked_exp_q.push_back(expv);
      n_casts++;
    end else begin
      map_cells[b * DEF_MAX_COLS + a] = CELL_W'(c);
      n_writes++;
    end
  endtask

  // Write one grid size register; the block must be idle.
  task automatic cfg_write(input int idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= GRID_DIM_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (CFG_IDX_W'(idx) == REG_GRID_WIDTH) grid_w = GRID_DIM_W'(val);
    else if (CFG_IDX_W'(idx) == REG_GRID_HEIGHT) grid_h = GRID_DIM_W'(val);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the block go idle.
  task automatic settle();
    int cnt;
    cnt = 0;
    start <= 1'b0;
    while (blocked_exp_q.size() != 0 && cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      cnt++;
    end
    if (blocked_exp_q.size() != 0) begin
      $display("%0t: %0d cast result(s) never arrived", $time, blocked_exp_q.size());
      n_err++;
      blocked_exp_q.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Draw the end points of one random cast of any shape.
  task automatic pick_cast(input int w, input int h, input int win_w, input int win_h,
                           output int sc, output int sr, output int ec, output int er);
    int d;
    case ($urandom_range(9))
      0, 1, 2: begin
        sc = int'($urandom_range(win_w - 1));
        sr = int'($urandom_range(win_h - 1));
        ec = int'($urandom_range(win_w - 1));
        er = int'($urandom_range(win_h - 1));
      end
      3, 4, 5: begin
        sc = int'($urandom_range(w - 1));
        sr = int'($urandom_range(h - 1));
        ec = int'($urandom_range(w - 1));
        er = int'($urandom_range(h - 1));
      end
      6: begin
        // Exact diagonal in any direction.
        sc = int'($urandom_range(w - 1));
        sr = int'($urandom_range(h - 1));
        d  = int'($urandom_range((w < h) ? w : h));
        ec = $urandom_range(1) ? sc + d : sc - d;
        er = $urandom_range(1) ? sr + d : sr - d;
      end
      7: begin
        // Zero length or along one axis.
        sc = int'($urandom_range(w - 1));
        sr = int'($urandom_range(h - 1));
        ec = sc;
        er = sr;
        case ($urandom_range(2))
          0: ec = int'($urandom_range(w - 1));
          1: er = int'($urandom_range(h - 1));
          default: ;
        endcase
      end
      8: begin
        // Around the grid border, partly outside.
        sc = int'($urandom_range(w + 5)) - 3;
        sr = int'($urandom_range(h + 5)) - 3;
        ec = int'($urandom_range(w + 5)) - 3;
        er = int'($urandom_range(h + 5)) - 3;
      end
      default: begin
        sc = int'($urandom_range(1023)) - 512;
        sr = int'($urandom_range(1023)) - 512;
        ec = int'($urandom_range(1023)) - 512;
        er = int'($urandom_range(1023)) - 512;
      end
    endcase
  endtask

  // Random items for the current grid size: writes and casts of every shape.
  task automatic random_phase(input int n_items);
    int w, h, win_w, win_h, sc, sr, ec, er, tries;
    w     = (int'(grid_w) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(grid_w);
    h     = (int'(grid_h) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(grid_h);
    w     = (w == 0) ? 1 : w;
    h     = (h == 0) ? 1 : h;
    win_w = (w > WIN_CELLS) ? WIN_CELLS : w;
    win_h = (h > WIN_CELLS) ? WIN_CELLS : h;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 35) begin
        // Writes mostly land in the small window that many rays cross.
        if ($urandom_range(9) < 7) begin
          sc = int'($urandom_range(win_w - 1));
          sr = int'($urandom_range(win_h - 1));
        end else begin
          sc = int'($urandom_range(255));
          sr = int'($urandom_range(255));
        end
        send_item(CMD_WRITE, sc, sr, $urandom_range(1) ? int'($urandom_range(3)) : 0,
                  int'($urandom_range(1023)) - 512, EXP_CALC);
      end else begin
        // A cast may only read written cells: redraw, then fall back to the window.
        tries = 0;
        do begin
          pick_cast(w, h, win_w, win_h, sc, sr, ec, er);
          tries++;
        end while ($isunknown(ray_blocked(sc, sr, ec, er)) && tries < CAST_TRIES);
        if ($isunknown(ray_blocked(sc, sr, ec, er))) begin
          sc = int'($urandom_range(win_w - 1));
          sr = int'($urandom_range(win_h - 1));
          ec = int'($urandom_range(win_w - 1));
          er = int'($urandom_range(win_h - 1));
        end
        send_item(CMD_CAST, sc, sr, ec, er, EXP_CALC);
      end
    end
  endtask

  // Result checker: each strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    logic expv;
    if (!rst && done) begin
      if (blocked_exp_q.size() == 0) begin
        $display("%0t: unexpected result, blocked=%0b with nothing expected", $time, blocked);
        n_err++;
      end else begin
        expv = blocked_exp_q.pop_front();
        if (blocked !== expv) begin
          $display("%0t: blocked mismatch, expected %0b, got %0b", $time, expv, blocked);
          n_err++;
        end
        if (blocked === 1'b1) n_hits++;
      end
    end
  end

  initial begin
    // Directed rows; the corner window of the map is clear when they start.
    dir_tab = '{
      '{ROW_CAST, 0, 0, 15, 15, 0},
      '{ROW_CAST, 0, 0, 0, 0, 0},
      '{ROW_CAST, 15, 0, 0, 15, 0},
      '{ROW_CAST, 0, 15, 15, 15, 0},
      '{ROW_CAST, -1, 0, 5, 0, 1},
      '{ROW_CAST, 0, 0, -3, 0, 1},
      '{ROW_CAST, -512, -512, 511, 511, 1},
      '{ROW_CAST, 511, 511, -512, -512, 1},
      '{ROW_WRITE, 10, 0, 2, 0, EXP_CALC},
      '{ROW_CAST, 0, 0, 20, 0, EXP_CALC},
      '{ROW_CAST, 0, 0, 20, 1, EXP_CALC},
      '{ROW_WRITE, 3, 3, 1, 0, EXP_CALC},
      '{ROW_CAST, 3, 0, 3, 9, EXP_CALC},
      '{ROW_CAST, 0, 3, 9, 3, EXP_CALC},
      '{ROW_CAST, 0, 0, 9, 9, EXP_CALC},
      '{ROW_WRITE, 1, 0, 3, 0, EXP_CALC},
      '{ROW_CAST, 0, 0, 2, 2, EXP_CALC},
      '{ROW_CAST, 1, 0, 1, 0, EXP_CALC},
      '{ROW_WRITE, 255, 255, 3, 0, EXP_CALC},
      '{ROW_CAST, 255, 255, 255, 255, EXP_CALC},
      '{ROW_WRITE, 255, 254, 0, 0, EXP_CALC},
      '{ROW_CFG, REG_GRID_WIDTH, 0, 0, 0, EXP_CALC},
      '{ROW_CAST, 0, 0, 0, 0, 1},
      '{ROW_CFG, REG_GRID_WIDTH, 511, 0, 0, EXP_CALC},
      '{ROW_CAST, 255, 254, 255, 254, 0},
      '{ROW_CFG, REG_UNUSED_A, 5, 0, 0, EXP_CALC},
      '{ROW_CFG, REG_UNUSED_B, 3, 0, 0, EXP_CALC},
      '{ROW_CAST, 255, 254, 255, 254, 0},
      '{ROW_CFG, REG_GRID_HEIGHT, 1, 0, 0, EXP_CALC},
      '{ROW_CAST, 0, 0, 0, 1, 1}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Clear the corner window back to back; casts only read written cells.
    for (int r = 0; r < WIN_CELLS; r++) begin
      for (int c = 0; c < WIN_CELLS; c++) begin
        send_item(CMD_WRITE, c, r, 0, 0, EXP_CALC);
      end
    end

    // Directed part.
    idle_en = 1'b1;
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: begin
          settle();
          cfg_write(dir_tab[i].a, dir_tab[i].b);
        end
        ROW_CAST: send_item(CMD_CAST, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c,
                            dir_tab[i].d, dir_tab[i].expv);
        default: send_item(CMD_WRITE, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c,
                           dir_tab[i].d, EXP_CALC);
      endcase
    end

    // Random phases, one grid size each.
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      cfg_write(REG_GRID_WIDTH, PHASE_W[p]);
      cfg_write(REG_GRID_HEIGHT, PHASE_H[p]);
      idle_en = PHASE_IDLE[p];
      random_phase(PHASE_ITEMS);
    end

    settle();
    $display("Covered %0d casts (%0d blocked) and %0d map writes, the clearing pass included.",
             n_casts, n_hits, n_writes);
    $display("Made %0d register writes over %0d grid sizes, zero and saturating ones among them.",
             n_cfg, N_PHASES + 3);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
hdl/glos_pkg.sv
hdl/glos_ram.sv
hdl/glos_ctrl.sv
hdl/glos_dp.sv
hdl/grid_line_of_sight_unit.sv
tb/tb.sv
